// ----- hw/rtl/lsqe_pkg.sv -----
`default_nettype none
package lsqe_pkg;

   localparam int StateBits = 4;

   localparam logic [StateBits-1:0] ST_IDLE = 4'd0;
   localparam logic [StateBits-1:0] ST_NORM = 4'd1;
   localparam logic [StateBits-1:0] ST_SQX  = 4'd2;
   localparam logic [StateBits-1:0] ST_SQY  = 4'd3;
   localparam logic [StateBits-1:0] ST_SUM  = 4'd4;
   localparam logic [StateBits-1:0] ST_SQRT = 4'd5;
   localparam logic [StateBits-1:0] ST_DIVX = 4'd6;
   localparam logic [StateBits-1:0] ST_DIVY = 4'd7;
   localparam logic [StateBits-1:0] ST_MULX = 4'd8;
   localparam logic [StateBits-1:0] ST_MULY = 4'd9;
   localparam logic [StateBits-1:0] ST_OFF  = 4'd10;
   localparam logic [StateBits-1:0] ST_E0   = 4'd11;
   localparam logic [StateBits-1:0] ST_E1   = 4'd12;
   localparam logic [StateBits-1:0] ST_E2   = 4'd13;
   localparam logic [StateBits-1:0] ST_E3   = 4'd14;

   typedef logic [StateBits-1:0] state_type;

   // first texture column of each stripe, indexed by width - 1
   function automatic logic [7:0] stripe_base(input logic [4:0] idx);
      logic [7:0] b;
      case (idx)
         5'd0:    b = 8'd2;
         5'd1:    b = 8'd6;
         5'd2:    b = 8'd11;
         5'd3:    b = 8'd17;
         5'd4:    b = 8'd24;
         5'd5:    b = 8'd32;
         5'd6:    b = 8'd41;
         5'd7:    b = 8'd51;
         5'd8:    b = 8'd62;
         5'd9:    b = 8'd74;
         5'd10:   b = 8'd87;
         5'd11:   b = 8'd101;
         5'd12:   b = 8'd116;
         5'd13:   b = 8'd132;
         5'd14:   b = 8'd149;
         5'd15:   b = 8'd167;
         5'd16:   b = 8'd186;
         5'd17:   b = 8'd206;
         5'd18:   b = 8'd227;
         default: b = 8'd2;
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/line_segment_quad_expander.sv -----
`default_nettype none
// Channel | Dir | Fields
// req_    | in  | tuser: new_strip; tdata: start_x, start_y, end_x, end_y, line_width
// rsp_    | out | tdata: corner_x, corner_y, tex_u, tex_v; tlast: last_corner
//
// A segment runs, from accept to the next accept, through normalizing shifts of
// long deltas, a 32-step square root and two 17-step divides (each after a load
// step; a zero-length segment skips root and divides), with squares and offsets
// through one multiplier, then four corners, each waiting for rsp_tready.
// req_tready is high only between segments. Reset (synchronous, high)
// clears the stored joint.
module line_segment_quad_expander #(
   parameter int COORD_BITS       = 20,
   parameter int MAX_STRIPE_WIDTH = 19
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   // new_strip
   input  wire                     req_tuser,
   // start_x, start_y, end_x, end_y, line_width, zero pad
   input  wire  [((4 * COORD_BITS + 9 + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   // corner_x, corner_y, tex_u, tex_v, zero pad
   output logic [((2 * COORD_BITS + 13 + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic                    rsp_tlast
);

   localparam int C     = COORD_BITS;
   localparam int RspW  = ((2 * C + 13 + 7) / 8) * 8;
   localparam int MW    = (C + 1 > 21) ? C + 1 : 21;
   localparam int WqMax = 16 * MAX_STRIPE_WIDTH;

   lsqe_pkg::state_type state_ff, state_in;

   logic signed [C-1:0] sx_ff, sy_ff, ex_ff, ey_ff;
   logic signed [C-1:0] prev_ex_ff, prev_ey_ff;
   logic signed [C-1:0] pplus_x_ff, pplus_y_ff, pminus_x_ff, pminus_y_ff;
   logic                joint_valid_ff, joint_ff;
   logic                nx_ff, ny_ff;
   logic [MW-1:0]       mx_ff, my_ff;
   logic [8:0]          wq_ff;
   logic [39:0]         prod_ff;
   logic [40:0]         n_ff;
   logic [63:0]         sq_x_ff;
   logic [33:0]         sq_rem_ff;
   logic [31:0]         root_ff;
   logic [31:0]         div_rem_ff;
   logic [16:0]         div_lo_ff;
   logic [16:0]         q_ff;
   logic [16:0]         ux_ff, uy_ff;
   logic [7:0]          hxm_ff, hym_ff;
   logic [4:0]          cnt_ff;
   logic                rsp_valid_ff;
   logic [RspW-1:0]     rsp_data_ff;
   logic                rsp_last_ff;

   // input unpack
   logic signed [C-1:0] in_sx, in_sy, in_ex, in_ey;
   logic [8:0]          in_lw;
   logic signed [C:0]   dx, dy;
   logic [C:0]          adx, ady;
   logic [9:0]          wq_raw;
   logic [8:0]          wq_clamped;
   logic                accept;

   assign in_sx  = req_tdata[C-1:0];
   assign in_sy  = req_tdata[2*C-1:C];
   assign in_ex  = req_tdata[3*C-1:2*C];
   assign in_ey  = req_tdata[4*C-1:3*C];
   assign in_lw  = req_tdata[4*C+8:4*C];
   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == lsqe_pkg::ST_IDLE);

   assign dx  = {in_ex[C-1], in_ex} - {in_sx[C-1], in_sx};
   assign dy  = {in_ey[C-1], in_ey} - {in_sy[C-1], in_sy};
   assign adx = dx[C] ? -dx : dx;
   assign ady = dy[C] ? -dy : dy;

   assign wq_raw     = {1'b0, in_lw} + 10'd8;
   assign wq_clamped = (wq_raw < 10'd16) ? 9'd16 :
                       (wq_raw > 10'(WqMax)) ? 9'(WqMax) : wq_raw[8:0];

   // shared multiplier
   logic [19:0] mul_a, mul_b;
   logic [39:0] mul_p;
   always_comb begin
      mul_a = mx_ff[19:0];
      mul_b = mx_ff[19:0];
      case (state_ff)
         lsqe_pkg::ST_SQY: begin
            mul_a = my_ff[19:0];
            mul_b = my_ff[19:0];
         end
         lsqe_pkg::ST_MULX: begin
            mul_a = {3'd0, uy_ff};
            mul_b = {11'd0, wq_ff};
         end
         lsqe_pkg::ST_MULY: begin
            mul_a = {3'd0, ux_ff};
            mul_b = {11'd0, wq_ff};
         end
         default: ;
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // root step
   logic [35:0] sq_rem2;
   logic [35:0] sq_trial;
   logic        sq_ge;
   assign sq_rem2  = {sq_rem_ff, sq_x_ff[63:62]};
   assign sq_trial = {2'd0, root_ff, 2'b01};
   assign sq_ge    = sq_rem2 >= sq_trial;

   // divide step
   logic [32:0] div_r2;
   logic        div_ge;
   assign div_r2 = {div_rem_ff, div_lo_ff[16]};
   assign div_ge = div_r2 >= {1'b0, root_ff};

   logic [16:0] q_next, q_clamped;
   assign q_next    = {q_ff[15:0], div_ge};
   assign q_clamped = (q_next > 17'd65536) ? 17'd65536 : q_next;

   logic [47:0] div_num_x, div_num_y;
   assign div_num_x = {1'b0, mx_ff[19:0], 27'd0} + {17'd0, root_ff[31:1]};
   assign div_num_y = {1'b0, my_ff[19:0], 27'd0} + {17'd0, root_ff[31:1]};

   logic [40:0] n_sum;
   assign n_sum = n_ff + {1'b0, prod_ff};

   logic [39:0] prod_rnd;
   assign prod_rnd = prod_ff + 40'd65536;

   logic norm_more;
   assign norm_more = (|mx_ff[MW-1:20]) || (|my_ff[MW-1:20]);

   // corner adder with saturation
   logic signed [8:0]   hx, hy, hsel_x, hsel_y;
   logic signed [C-1:0] base_x, base_y;
   logic signed [C+1:0] sum_x, sum_y;
   logic signed [C-1:0] cx, cy, ox, oy;
   logic                add_h;

   function automatic logic signed [C-1:0] sat(input logic signed [C+1:0] v);
      logic signed [C+1:0] vmax, vmin;
      vmax = (C+2)'({1'b0, {(C-1){1'b1}}});
      vmin = -vmax - (C+2)'(1);
      if (v > vmax) return vmax[C-1:0];
      if (v < vmin) return vmin[C-1:0];
      return v[C-1:0];
   endfunction

   assign hx = ny_ff ? $signed({1'b0, hxm_ff}) : -$signed({1'b0, hxm_ff});
   assign hy = nx_ff ? -$signed({1'b0, hym_ff}) : $signed({1'b0, hym_ff});
   assign add_h  = (state_ff == lsqe_pkg::ST_E1) || (state_ff == lsqe_pkg::ST_E2);
   assign hsel_x = add_h ? hx : -hx;
   assign hsel_y = add_h ? hy : -hy;
   assign base_x = (state_ff == lsqe_pkg::ST_E0 || state_ff == lsqe_pkg::ST_E1) ? sx_ff : ex_ff;
   assign base_y = (state_ff == lsqe_pkg::ST_E0 || state_ff == lsqe_pkg::ST_E1) ? sy_ff : ey_ff;
   assign sum_x  = (C+2)'(base_x) + (C+2)'(hsel_x);
   assign sum_y  = (C+2)'(base_y) + (C+2)'(hsel_y);
   assign cx     = sat(sum_x);
   assign cy     = sat(sum_y);

   always_comb begin
      ox = cx;
      oy = cy;
      if (joint_ff && state_ff == lsqe_pkg::ST_E0) begin
         ox = pminus_x_ff;
         oy = pminus_y_ff;
      end else if (joint_ff && state_ff == lsqe_pkg::ST_E1) begin
         ox = pplus_x_ff;
         oy = pplus_y_ff;
      end
   end

   logic [4:0] w_px;
   logic [7:0] ub, uw, tu;
   logic [4:0] tv;
   logic       emit, out_free, last_in;
   assign w_px     = wq_ff[8:4];
   assign ub       = lsqe_pkg::stripe_base(w_px - 5'd1);
   assign uw       = ub + {3'd0, w_px} + 8'd2;
   assign tu       = add_h ? uw : ub;
   assign tv       = (state_ff == lsqe_pkg::ST_E2 || state_ff == lsqe_pkg::ST_E3) ? 5'd16 : 5'd0;
   assign last_in  = (state_ff == lsqe_pkg::ST_E3);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign emit     = out_free && (state_ff == lsqe_pkg::ST_E0 || state_ff == lsqe_pkg::ST_E1 ||
                                  state_ff == lsqe_pkg::ST_E2 || state_ff == lsqe_pkg::ST_E3);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lsqe_pkg::ST_IDLE: if (accept) state_in = lsqe_pkg::ST_NORM;
         lsqe_pkg::ST_NORM: if (!norm_more) state_in = lsqe_pkg::ST_SQX;
         lsqe_pkg::ST_SQX:  state_in = lsqe_pkg::ST_SQY;
         lsqe_pkg::ST_SQY:  state_in = lsqe_pkg::ST_SUM;
         lsqe_pkg::ST_SUM:  state_in = (n_sum == 41'd0) ? lsqe_pkg::ST_MULX : lsqe_pkg::ST_SQRT;
         lsqe_pkg::ST_SQRT: if (cnt_ff == 5'd31) state_in = lsqe_pkg::ST_DIVX;
         lsqe_pkg::ST_DIVX: if (cnt_ff == 5'd17) state_in = lsqe_pkg::ST_DIVY;
         lsqe_pkg::ST_DIVY: if (cnt_ff == 5'd17) state_in = lsqe_pkg::ST_MULX;
         lsqe_pkg::ST_MULX: state_in = lsqe_pkg::ST_MULY;
         lsqe_pkg::ST_MULY: state_in = lsqe_pkg::ST_OFF;
         lsqe_pkg::ST_OFF:  state_in = lsqe_pkg::ST_E0;
         lsqe_pkg::ST_E0:   if (out_free) state_in = lsqe_pkg::ST_E1;
         lsqe_pkg::ST_E1:   if (out_free) state_in = lsqe_pkg::ST_E2;
         lsqe_pkg::ST_E2:   if (out_free) state_in = lsqe_pkg::ST_E3;
         lsqe_pkg::ST_E3:   if (out_free) state_in = lsqe_pkg::ST_IDLE;
         default:           state_in = lsqe_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= lsqe_pkg::ST_IDLE;
         joint_valid_ff <= 1'b0;
         prev_ex_ff     <= '0;
         prev_ey_ff     <= '0;
         pplus_x_ff     <= '0;
         pplus_y_ff     <= '0;
         pminus_x_ff    <= '0;
         pminus_y_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            // decide the joint against the previous segment, then take over its end
            joint_ff       <= joint_valid_ff && !req_tuser &&
                              prev_ex_ff == in_sx && prev_ey_ff == in_sy;
            joint_valid_ff <= 1'b1;
            prev_ex_ff     <= in_ex;
            prev_ey_ff     <= in_ey;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
            if (state_ff == lsqe_pkg::ST_E2) begin
               pplus_x_ff <= cx;
               pplus_y_ff <= cy;
            end
            if (state_ff == lsqe_pkg::ST_E3) begin
               pminus_x_ff <= cx;
               pminus_y_ff <= cy;
            end
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= RspW'({tv, tu, oy, ox});
         rsp_last_ff <= last_in;
      end
      case (state_ff)
         lsqe_pkg::ST_IDLE: begin
            sx_ff <= in_sx;
            sy_ff <= in_sy;
            ex_ff <= in_ex;
            ey_ff <= in_ey;
            nx_ff <= dx[C];
            ny_ff <= dy[C];
            mx_ff <= MW'(adx[C-1:0]);
            my_ff <= MW'(ady[C-1:0]);
            wq_ff <= wq_clamped;
         end
         lsqe_pkg::ST_NORM: begin
            // halve both until the larger fits 20 bits
            if (norm_more) begin
               mx_ff <= mx_ff >> 1;
               my_ff <= my_ff >> 1;
            end
            prod_ff <= mul_p;
         end
         lsqe_pkg::ST_SQX: prod_ff <= mul_p;
         lsqe_pkg::ST_SQY: begin
            n_ff    <= {1'b0, prod_ff};
            prod_ff <= mul_p;
         end
         lsqe_pkg::ST_SUM: begin
            sq_x_ff   <= {1'b0, n_sum, 22'd0};
            sq_rem_ff <= '0;
            root_ff   <= '0;
            cnt_ff    <= '0;
            ux_ff     <= '0;
            uy_ff     <= '0;
         end
         lsqe_pkg::ST_SQRT: begin
            sq_x_ff <= {sq_x_ff[61:0], 2'b00};
            if (sq_ge) begin
               sq_rem_ff <= 34'(sq_rem2 - sq_trial);
               root_ff   <= {root_ff[30:0], 1'b1};
            end else begin
               sq_rem_ff <= sq_rem2[33:0];
               root_ff   <= {root_ff[30:0], 1'b0};
            end
            if (cnt_ff == 5'd31) begin
               cnt_ff <= '0;
            end else begin
               cnt_ff <= cnt_ff + 5'd1;
            end
         end
         lsqe_pkg::ST_DIVX, lsqe_pkg::ST_DIVY: begin
            if (cnt_ff == 5'd0) begin
               // load numerator m * 2^27 + s / 2
               if (state_ff == lsqe_pkg::ST_DIVX) begin
                  div_rem_ff <= {1'b0, div_num_x[47:17]};
                  div_lo_ff  <= div_num_x[16:0];
               end else begin
                  div_rem_ff <= {1'b0, div_num_y[47:17]};
                  div_lo_ff  <= div_num_y[16:0];
               end
               q_ff   <= '0;
               cnt_ff <= 5'd1;
            end else begin
               div_rem_ff <= div_ge ? 32'(div_r2 - {1'b0, root_ff}) : div_r2[31:0];
               div_lo_ff  <= {div_lo_ff[15:0], 1'b0};
               q_ff       <= q_next;
               if (cnt_ff == 5'd17) begin
                  cnt_ff <= '0;
                  if (state_ff == lsqe_pkg::ST_DIVX) ux_ff <= q_clamped;
                  else uy_ff <= q_clamped;
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
         end
         lsqe_pkg::ST_MULX: prod_ff <= mul_p;
         lsqe_pkg::ST_MULY: begin
            hxm_ff  <= prod_rnd[24:17];
            prod_ff <= mul_p;
         end
         lsqe_pkg::ST_OFF: hym_ff <= prod_rnd[24:17];
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire
